// ----- sv/sack_pkg.sv -----
package sack_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned PointW      = IndexW + 1;
  localparam int unsigned BytesW      = 14;
  localparam int unsigned HeaderW     = 8;
  localparam int unsigned OffsetW     = 20;
  localparam int unsigned CountW      = 32;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgSegmentBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeaderBytes  = 1'b1;

  localparam logic [BytesW-1:0]  SegmentBytesRst = 14'd1460;
  localparam logic [HeaderW-1:0] HeaderBytesRst  = 8'd40;
  localparam logic [OffsetW-1:0] PayloadMax      = '1;

  typedef struct packed {
    logic [IndexW-1:0] segment_index;
    logic [BytesW-1:0] packet_bytes;
  } in_t;

  typedef struct packed {
    logic [OffsetW-1:0] cumulative_ack;
    logic [OffsetW-1:0] sack_offset;
    logic               sack_valid;
    logic               was_duplicate;
    logic [OffsetW-1:0] payload_total;
    logic               last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StUpdate,
    StAdvance,
    StAck,
    StList,
    StFinal
  } state_e;

  // sequencer -> datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic advance;
    logic ack_load;
    logic list_step;
    logic emit_mid;
    logic emit_last;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic ign;
    logic adv_hit;
    logic scan_end;
    logic bit_set;
    logic pend;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/sack_receiver_scoreboard.sv -----
// Selective-ack receive scoreboard. Each item is one arriving segment; the block
// marks it in a 64-entry received map, adds its payload to a saturating total,
// advances the in-order point and then reports the cumulative ack plus one
// result per received segment beyond the first gap (an ack-only result when
// there is none), the final one flagged last_of_run. A sequencer walks the map
// one index per cycle, pausing while listing if an earlier result still waits
// in the output register (an index at or beyond MAX_SEGMENTS skips the walk),
// and a single 7x14 multiplier turns the ack and each listed index into a byte
// offset. in_ready_o is high only between items; results leave through an
// output register, so the next item may be taken while the last result still
// waits.
// Configuration (index 0 segment size, index 1 header size) is always ready.
module sack_receiver_scoreboard #(
  parameter int unsigned MAX_SEGMENTS = sack_pkg::MaxSegments
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sack_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sack_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sack_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sack_pkg::BytesW-1:0]  cfg_data_i
);

  sack_pkg::ctl_t ctl;
  sack_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sack_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sack_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

// ----- sv/sack_ctrl.sv -----
module sack_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sack_pkg::sts_t  sts_i,
  output sack_pkg::ctl_t  ctl_o
);

  sack_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sack_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sack_pkg::StIdle: begin
        if (in_valid_i) state_d = sack_pkg::StUpdate;
      end
      sack_pkg::StUpdate: begin
        state_d = sts_i.ign ? sack_pkg::StAck : sack_pkg::StAdvance;
      end
      sack_pkg::StAdvance: begin
        if (!sts_i.adv_hit) state_d = sack_pkg::StAck;
      end
      sack_pkg::StAck: begin
        state_d = sts_i.ign ? sack_pkg::StFinal : sack_pkg::StList;
      end
      sack_pkg::StList: begin
        if (sts_i.scan_end) state_d = sack_pkg::StFinal;
      end
      sack_pkg::StFinal: begin
        if (sts_i.out_free) state_d = sack_pkg::StIdle;
      end
      default: state_d = sack_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sack_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
      end
      sack_pkg::StUpdate: begin
        ctl_o.update = 1'b1;
      end
      sack_pkg::StAdvance: begin
        ctl_o.advance = sts_i.adv_hit;
      end
      sack_pkg::StAck: begin
        ctl_o.ack_load = 1'b1;
      end
      sack_pkg::StList: begin
        // an earlier entry must leave before a new one is held
        if (!sts_i.scan_end && !(sts_i.bit_set && sts_i.pend && !sts_i.out_free)) begin
          ctl_o.list_step = 1'b1;
          ctl_o.emit_mid  = sts_i.bit_set && sts_i.pend;
        end
      end
      sack_pkg::StFinal: begin
        ctl_o.emit_last = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/sack_dp.sv -----
module sack_dp #(
  parameter int unsigned MAX_SEGMENTS = sack_pkg::MaxSegments
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sack_pkg::in_t                       in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [sack_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sack_pkg::BytesW-1:0]         cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output sack_pkg::out_t                      out_data_o,
  input  sack_pkg::ctl_t                      ctl_i,
  output sack_pkg::sts_t                      sts_o
);

  // only indexes below 64 can ever arrive
  localparam int unsigned MapDepth = (MAX_SEGMENTS < 64) ? MAX_SEGMENTS : 64;
  localparam int unsigned MapIw    = $clog2(MapDepth);

  logic [sack_pkg::BytesW-1:0]  seg_bytes_q;
  logic [sack_pkg::HeaderW-1:0] hdr_bytes_q;

  sack_pkg::in_t                in_q;
  logic [MapDepth-1:0]          map_q;
  logic [sack_pkg::IndexW-1:0]  hi_q;
  logic [sack_pkg::PointW-1:0]  point_q;
  logic [sack_pkg::PointW-1:0]  s_q;
  logic [sack_pkg::OffsetW-1:0] pay_q;
  logic [sack_pkg::CountW-1:0]  dup_cnt_q;
  logic                         dup_q;
  logic                         ign_q;
  logic [sack_pkg::OffsetW-1:0] ack_q;
  logic                         pend_q;
  logic [sack_pkg::OffsetW-1:0] pend_off_q;
  logic                         out_valid_q;
  sack_pkg::out_t               out_q;

  logic                         ign;
  logic [MapIw-1:0]             in_idx;
  logic                         in_seen;
  logic [sack_pkg::BytesW:0]    pay_add;
  logic [sack_pkg::OffsetW:0]   pay_sum;
  logic                         s_in_range;
  logic                         s_bit;
  logic [sack_pkg::PointW-1:0]  mul_a;
  logic [sack_pkg::PointW+sack_pkg::BytesW-1:0] mul_p;

  assign ign     = 32'(in_q.segment_index) >= MAX_SEGMENTS;
  assign in_idx  = in_q.segment_index[MapIw-1:0];
  assign in_seen = map_q[in_idx];
  assign pay_add = (in_q.packet_bytes > sack_pkg::BytesW'(hdr_bytes_q))
                 ? {1'b0, in_q.packet_bytes - sack_pkg::BytesW'(hdr_bytes_q)} : '0;
  assign pay_sum = {1'b0, pay_q} + (sack_pkg::OffsetW + 1)'(pay_add);

  assign s_in_range = s_q <= sack_pkg::PointW'(hi_q);
  assign s_bit      = s_in_range && map_q[s_q[MapIw-1:0]];

  // shared multiplier: ack in the ack step, entry offsets while listing
  assign mul_a = ctl_i.ack_load ? point_q : s_q;
  assign mul_p = (sack_pkg::PointW + sack_pkg::BytesW)'(mul_a) *
                 (sack_pkg::PointW + sack_pkg::BytesW)'(seg_bytes_q);

  assign sts_o.ign      = ign;
  assign sts_o.adv_hit  = s_bit;
  assign sts_o.scan_end = !s_in_range || ign_q;
  assign sts_o.bit_set  = s_bit;
  assign sts_o.pend     = pend_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_bytes_q <= sack_pkg::SegmentBytesRst;
      hdr_bytes_q <= sack_pkg::HeaderBytesRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sack_pkg::CfgSegmentBytes: seg_bytes_q <= cfg_data_i;
        sack_pkg::CfgHeaderBytes:  hdr_bytes_q <= cfg_data_i[sack_pkg::HeaderW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) in_q <= in_data_i;
    if (ctl_i.ack_load) ack_q <= mul_p[sack_pkg::OffsetW-1:0];
    if (ctl_i.list_step && s_bit) pend_off_q <= mul_p[sack_pkg::OffsetW-1:0];
    if (ctl_i.update) begin
      dup_q <= !ign && in_seen;
      ign_q <= ign;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= '0;
      hi_q      <= '0;
      point_q   <= '0;
      s_q       <= '0;
      pay_q     <= '0;
      dup_cnt_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (ctl_i.update) begin
        s_q    <= point_q;
        pend_q <= 1'b0;
        if (!ign) begin
          if (in_seen) begin
            dup_cnt_q <= dup_cnt_q + 1'b1;
          end else begin
            map_q[in_idx] <= 1'b1;
            pay_q <= pay_sum[sack_pkg::OffsetW] ? sack_pkg::PayloadMax
                                                : pay_sum[sack_pkg::OffsetW-1:0];
          end
          if (in_q.segment_index > hi_q) hi_q <= in_q.segment_index;
        end
      end
      if (ctl_i.advance) begin
        s_q     <= s_q + 1'b1;
        point_q <= s_q + 1'b1;
      end
      if (ctl_i.list_step) begin
        s_q <= s_q + 1'b1;
        if (s_bit) pend_q <= 1'b1;
      end
      if (ctl_i.emit_last) pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit_mid || ctl_i.emit_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_mid || ctl_i.emit_last) begin
      out_q.cumulative_ack <= ack_q;
      out_q.sack_offset    <= pend_q ? pend_off_q : '0;
      out_q.sack_valid     <= pend_q;
      out_q.was_duplicate  <= dup_q;
      out_q.payload_total  <= pay_q;
      out_q.last_of_run    <= ctl_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/sack_checker.sv -----
module sack_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input sack_pkg::in_t                in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input sack_pkg::out_t               out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [sack_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [sack_pkg::BytesW-1:0]  cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready straight after an item");

  a_ack_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sack_valid |->
      out_data_o.last_of_run && (out_data_o.sack_offset == '0))
    else $error("ack-only result malformed");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !in_ready_o)
    else $error("idle with a run still open");

endmodule

bind sack_receiver_scoreboard sack_checker u_sack_checker (.*);
